// File: hw/rtl/fwds_pkg.sv
// Shared types and constants for the FIFO with delete and search.
package fwds_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned CAP_W  = 5;
	localparam int unsigned CNT_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic  push;
		logic  del;
		word_t value;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/fwds_cell.sv
// One storage cell of the shift chain: holds an entry, compares it and passes data along.
module fwds_cell (
	input  logic               clk,
	input  fwds_pkg::cell_ctrl_t ctrl,
	input  fwds_pkg::word_t    prev_entry,
	input  fwds_pkg::word_t    next_entry,
	input  logic               occupied,
	input  logic               oldest,
	input  logic               found_in,
	output logic               found_out,
	input  fwds_pkg::word_t    rd_in,
	output fwds_pkg::word_t    rd_out,
	output fwds_pkg::word_t    entry
);
	import fwds_pkg::*;

	word_t entry_q;
	logic  hit;

	assign hit       = occupied && (entry_q == ctrl.value);
	assign found_out = found_in | hit;
	assign rd_out    = rd_in | (oldest ? entry_q : '0);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= prev_entry;
		end else if (ctrl.del && found_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// File: hw/rtl/fifo_with_delete_and_search.sv
// Top level of the FIFO with delete and search, built as a chain of storage cells.
//
//   channel  direction  signals
//   cfg      in         cfg_valid, cfg_ready, cfg_data
//   in       in         in_valid, in_ready, opcode, value
//   out      out        out_valid, out_ready, ok, data, count
//
// Each request's result is registered; a new beat is taken each cycle while the result
// register is empty or being drained. The rate is set by the compare and shift that
// all cells do together. Reset empties the store and sets the capacity to sixteen.
// A stalled result holds the input channel off until it is taken. Configuration
// beats are always taken.
module fifo_with_delete_and_search #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fwds_pkg::CAP_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fwds_pkg::OP_W-1:0]     opcode,
	input  logic signed [fwds_pkg::DATA_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic signed [fwds_pkg::DATA_W-1:0] data,
	output logic [fwds_pkg::CNT_W-1:0]    count
);
	import fwds_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    occ_q;
	logic [CW-1:0]    occ_next;
	logic             out_valid_q;
	logic             ok_q;
	word_t            data_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             push_ok;
	logic             nonempty;
	logic             res_ok;
	word_t            res_data;
	cell_ctrl_t       ctrl;

	logic [DEPTH:0]   found_w;
	word_t            rd_w [DEPTH:0];
	word_t            entry_w [DEPTH-1:0];

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	assign nonempty = (occ_q != '0);
	assign push_ok  = (LW'(occ_q) < LW'(cap_q)) && (LW'(occ_q) < LW'(DEPTH));

	assign found_w[0]   = 1'b0;
	assign rd_w[DEPTH]  = '0;

	always_comb begin
		ctrl.push  = 1'b0;
		ctrl.del   = 1'b0;
		ctrl.value = value;
		res_ok     = 1'b0;
		res_data   = '0;
		occ_next   = occ_q;
		case (opcode)
			OP_PUSH: begin
				res_ok    = push_ok;
				ctrl.push = accept && push_ok;
				if (push_ok) begin
					occ_next = occ_q + CW'(1);
				end
			end
			OP_POP: begin
				res_ok = nonempty;
				if (nonempty) begin
					res_data = rd_w[0];
					occ_next = occ_q - CW'(1);
				end
			end
			OP_DELETE: begin
				res_ok   = found_w[DEPTH];
				ctrl.del = accept;
				if (found_w[DEPTH]) begin
					occ_next = occ_q - CW'(1);
				end
			end
			OP_FIND: begin
				res_ok = found_w[DEPTH];
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			word_t prev_e;
			word_t next_e;
			if (k == 0) begin : g_first
				assign prev_e = value;
			end else begin : g_mid_prev
				assign prev_e = entry_w[k-1];
			end
			if (k == DEPTH - 1) begin : g_last
				assign next_e = entry_w[k];
			end else begin : g_mid_next
				assign next_e = entry_w[k+1];
			end
			fwds_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.prev_entry (prev_e),
				.next_entry (next_e),
				.occupied   (CW'(k) < occ_q),
				.oldest     (occ_q == CW'(k + 1)),
				.found_in   (found_w[k]),
				.found_out  (found_w[k+1]),
				.rd_in      (rd_w[k+1]),
				.rd_out     (rd_w[k]),
				.entry      (entry_w[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				occ_q       <= occ_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= res_ok;
			data_q  <= res_data;
			count_q <= CNT_W'(occ_next);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign data      = data_q;
	assign count     = count_q;

endmodule

// File: hw/rtl/fwds_chk.sv
// Port checker for the FIFO with delete and search, bound to the top level.
module fwds_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          ok,
	input  logic signed [fwds_pkg::DATA_W-1:0] data,
	input  logic [fwds_pkg::CNT_W-1:0]    count
);
	import fwds_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("An accepted request beat gave no result beat.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input held off while no result was waiting.");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (data == '0))
		else $error("A failed request returned nonzero data.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(ok) && $stable(data) && $stable(count)))
		else $error("A stalled result beat changed.");

endmodule

bind fifo_with_delete_and_search fwds_chk u_fwds_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ok        (ok),
	.data      (data),
	.count     (count)
);

// File: tb/sv/fwds_tb_pkg.sv
// Scoreboard class that mirrors the store contents and checks every result beat.
`timescale 1ns / 100ps
package fwds_tb_pkg;
	import fwds_pkg::*;

	localparam int STORE_DEPTH = 16;

	typedef struct {
		logic             ok;
		word_t            data;
		logic [CNT_W-1:0] count;
	} reply_t;

	class fwds_checker;
		word_t       mirror_words[$];
		reply_t      pending_replies[$];
		int unsigned capacity = 32'(CAP_RESET);
		int unsigned mismatches = 0;
		int unsigned requests = 0;
		int unsigned results = 0;
		int unsigned cap_writes = 0;
		int unsigned refused_pushes = 0;
		int unsigned empty_pops = 0;
		int unsigned delete_hits = 0;
		int unsigned delete_misses = 0;
		int unsigned find_hits = 0;
		int unsigned find_misses = 0;
		int unsigned peak_fill = 0;

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = 32'(c);
			cap_writes++;
		endfunction

		function int unsigned outstanding();
			return pending_replies.size();
		endfunction

		function void predict_request(logic [OP_W-1:0] op, word_t v);
			reply_t r;
			int hit;
			int limit;
			r.ok = 1'b0;
			r.data = '0;
			hit = -1;
			limit = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
			requests++;
			case (op)
				OP_PUSH: begin
					if (mirror_words.size() < limit) begin
						mirror_words.push_front(v);
						r.ok = 1'b1;
					end else begin
						refused_pushes++;
					end
				end
				OP_POP: begin
					if (mirror_words.size() > 0) begin
						r.data = mirror_words.pop_back();
						r.ok = 1'b1;
					end else begin
						empty_pops++;
					end
				end
				OP_DELETE: begin
					foreach (mirror_words[k])
						if (hit < 0 && mirror_words[k] == v)
							hit = k;
					if (hit >= 0) begin
						mirror_words.delete(hit);
						r.ok = 1'b1;
						delete_hits++;
					end else begin
						delete_misses++;
					end
				end
				default: begin
					foreach (mirror_words[k])
						if (mirror_words[k] == v)
							r.ok = 1'b1;
					if (r.ok)
						find_hits++;
					else
						find_misses++;
				end
			endcase
			r.count = CNT_W'(mirror_words.size());
			if (mirror_words.size() > peak_fill)
				peak_fill = mirror_words.size();
			pending_replies.push_back(r);
		endfunction

		function void check_result(logic ok, word_t data, logic [CNT_W-1:0] count);
			reply_t e;
			results++;
			if (pending_replies.size() == 0) begin
				$error("result beat with no request waiting: ok=%0b data=%h count=%0d",
					ok, data, count);
				mismatches++;
				return;
			end
			e = pending_replies.pop_front();
			if (ok !== e.ok) begin
				$error("ok: expected %0b, actual %0b", e.ok, ok);
				mismatches++;
			end
			if (data !== e.data) begin
				$error("data: expected %h, actual %h", e.data, data);
				mismatches++;
			end
			if (count !== e.count) begin
				$error("count: expected %0d, actual %0d", e.count, count);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench for the FIFO with delete and search.
`timescale 1ns / 100ps
module tb_top;
	import fwds_pkg::*;
	import fwds_tb_pkg::*;

	localparam int LONG_HOLD   = 80;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 112;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CAP_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    opcode = OP_FIND;
	logic signed [DATA_W-1:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               ok;
	logic signed [DATA_W-1:0] data;
	logic [CNT_W-1:0]   count;

	bit          hold_req = 1'b0;
	int unsigned quiet_cycles = 0;
	word_t       value_pool[8];
	fwds_checker sb = new;

	fifo_with_delete_and_search #(
		.DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.data(data),
		.count(count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(ok, data, count);
			if (in_valid && in_ready)
				sb.predict_request(opcode, value);
			if (cfg_valid && cfg_ready)
				sb.set_capacity(cfg_data);
			if ((out_valid && out_ready) || (in_valid && in_ready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int          seg_left;
		int          mode;
		int          step;
		int          stall_left;
		logic [7:0]  pattern;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				stall_left = LONG_HOLD;
				while (stall_left > 0) begin
					@(posedge clk);
					stall_left--;
				end
			end else begin
				seg_left = $urandom_range(4, 40);
				mode = $urandom_range(0, 2);
				pattern = 8'($urandom);
				step = 0;
				while (seg_left > 0 && !hold_req) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= pattern[step % 8];
					endcase
					@(posedge clk);
					seg_left--;
					step++;
				end
			end
		end
	end

	task automatic offer(input logic [OP_W-1:0] op, input word_t v);
		in_valid <= 1'b1;
		opcode <= op;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic refresh_pool();
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;
		value_pool[6] = $urandom_range(1, 4);
		value_pool[7] = $urandom_range(1, 4);
	endtask

	task automatic random_phase(input int n);
		int           left;
		int           burst;
		int           gap;
		int           push_pct;
		int           roll;
		logic [OP_W-1:0] op;
		word_t        v;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			case ($urandom_range(0, 2))
				0: push_pct = 25;
				1: push_pct = 50;
				default: push_pct = 75;
			endcase
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < push_pct)
					op = OP_PUSH;
				else if (roll < push_pct + (100 - push_pct) * 4 / 10)
					op = OP_POP;
				else if ($urandom_range(0, 1) == 0)
					op = OP_DELETE;
				else
					op = OP_FIND;
				if ($urandom_range(0, 9) < 7)
					v = value_pool[3'($urandom_range(0, 7))];
				else
					v = $urandom;
				offer(op, v);
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (left == 0 || gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps[PHASES];
		caps = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd17, 5'd8, 5'd2, 5'd5, 5'd16};
		caps[8] = CAP_W'($urandom_range(0, 31));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(OP_POP, 32'h0000_0000);
		offer(OP_DELETE, 32'h0000_0005);
		offer(OP_FIND, 32'h0000_0000);
		offer(OP_PUSH, 32'h8000_0000);
		offer(OP_PUSH, 32'h7fff_ffff);
		offer(OP_PUSH, 32'h0000_0000);
		offer(OP_PUSH, 32'hffff_ffff);
		offer(OP_PUSH, 32'h7fff_ffff);
		offer(OP_FIND, 32'h8000_0000);
		offer(OP_FIND, 32'h1234_5678);
		offer(OP_DELETE, 32'h7fff_ffff);
		offer(OP_DELETE, 32'h5555_5555);
		offer(OP_POP, 32'hffff_ffff);
		offer(OP_POP, 32'h0000_0000);
		offer(OP_PUSH, 32'haaaa_aaaa);
		offer(OP_PUSH, 32'h5555_5555);
		in_valid <= 1'b0;
		write_capacity(5'd2);
		offer(OP_PUSH, 32'h0000_0001);
		offer(OP_DELETE, 32'h0000_0000);
		offer(OP_POP, 32'h0000_0000);
		offer(OP_POP, 32'h0000_0000);
		offer(OP_PUSH, 32'h0000_0002);
		offer(OP_PUSH, 32'h0000_0003);
		in_valid <= 1'b0;
		write_capacity(5'd0);
		offer(OP_PUSH, 32'h0000_0004);
		offer(OP_POP, 32'h0000_0000);
		offer(OP_POP, 32'h0000_0000);
		offer(OP_POP, 32'h0000_0000);
		in_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(caps[p]);
			refresh_pool();
			if (p == 2 || p == 6)
				hold_req = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d requests and %0d result beats over %0d capacity writes,",
			sb.requests, sb.results, sb.cap_writes);
		$display("peak fill %0d, refused pushes %0d, empty pops %0d,",
			sb.peak_fill, sb.refused_pushes, sb.empty_pops);
		$display("delete hit/miss %0d/%0d, find hit/miss %0d/%0d.",
			sb.delete_hits, sb.delete_misses, sb.find_hits, sb.find_misses);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
